// File: sv/rrs_pkg.sv
// Shared constants for the round-robin slot scheduler.
// Holds pool sizing, opcode and status codes; no dependencies.
package rrs_pkg;

  localparam int SLOTS     = 32;
  localparam int NAME_BITS = 64;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  // slot data word: {name, budget, id}
  localparam int DATA_W = NAME_BITS + 32;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [2:0] ST_CREATED  = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_REQUEUED = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;
  localparam logic [2:0] ST_REMOVED  = 3'd5;
  localparam logic [2:0] ST_NOTFOUND = 3'd6;

endpackage

// File: sv/round_robin_slot_scheduler.sv
// Round-robin slot scheduler: top level with sequencer, list pointers and output register.
// Depends on rrs_pkg and two rrs_ram instances (next links, slot data).
//
// Usage: one command beat enters on the input channel (opcode, name tag,
// slice budget) and exactly one result beat leaves on the output channel
// (status, task id, slot, ready and free counts after the command).
// Both channels use valid/stall; a beat moves when valid is high and
// stall is low. in_stall_o is high while a command is being worked on.
// Path from accept to result valid, by state:
//   create: S_CRT, S_APP, S_DONE; pool full: straight to S_DONE
//   tick:   S_TICK, then S_DONE when the task finishes, or S_APP, S_DONE
//           when requeued; idle: straight to S_DONE
//   remove: S_SRCH from the head up to the match, S_FREE, S_DONE; not found:
//           S_SRCH over the whole ready queue, S_DONE (empty queue: S_DONE)
// The remove search reads one link per cycle from the next-pointer RAM.
// A finished result waits in an output register while the receiver
// stalls; the next command is taken meanwhile and its result waits until
// the register empties. Reset empties the ready queue, puts every slot on
// the free list in ascending order and restarts task ids at zero; the
// link RAM reads its reset contents through per-slot valid bits, so the
// block takes commands right after reset.
module round_robin_slot_scheduler
  import rrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] name_tag_i,
  input  logic [15:0] slice_budget_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] task_id_o,
  output logic [7:0]  slot_index_o,
  output logic [8:0]  ready_count_o,
  output logic [8:0]  free_count_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CRT  = 3'd1;
  localparam logic [2:0] S_TICK = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_FREE = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [SLOT_W-1:0]    ready_head_q, ready_head_d;
  logic [SLOT_W-1:0]    ready_tail_q, ready_tail_d;
  logic [CNT_W-1:0]     ready_size_q, ready_size_d;
  logic [SLOT_W-1:0]    free_head_q, free_head_d;
  logic [CNT_W-1:0]     free_size_q, free_size_d;
  logic [15:0]          next_id_q, next_id_d;

  logic [1:0]           op_q, op_d;
  logic [NAME_BITS-1:0] name_q, name_d;
  logic [15:0]          budget_q, budget_d;
  logic [SLOT_W-1:0]    cur_q, cur_d;
  logic [SLOT_W-1:0]    prev_q, prev_d;
  logic [CNT_W-1:0]     k_q, k_d;

  logic [2:0]           res_status_q, res_status_d;
  logic [15:0]          res_id_q, res_id_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;

  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_status_q;
  logic [15:0]          out_id_q;
  logic [7:0]           out_slot_q;
  logic [8:0]           out_ready_q;
  logic [8:0]           out_free_q;
  logic                 out_load;

  // link RAM ports and valid bits
  logic                 nx_we;
  logic [SLOT_W-1:0]    nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [SLOTS-1:0]     nx_vld_q;
  logic                 nx_rvld_q;
  logic [SLOT_W-1:0]    nx_raddr_q;
  logic [SLOT_W-1:0]    rd_next;

  // slot data RAM ports
  logic                 dt_we;
  logic [SLOT_W-1:0]    dt_waddr, dt_raddr;
  logic [DATA_W-1:0]    dt_wdata, dt_rdata;

  logic [NAME_BITS-1:0] rd_name;
  logic [15:0]          rd_budget, rd_id;
  logic signed [16:0]   bdec;
  logic                 done_run;
  logic                 last_k;
  logic                 accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign rd_name   = dt_rdata[DATA_W-1 -: NAME_BITS];
  assign rd_budget = dt_rdata[31:16];
  assign rd_id     = dt_rdata[15:0];

  // never-written link reads as its reset value i+1, wrapping at the pool end
  assign rd_next = nx_rvld_q ? nx_rdata :
                   ((nx_raddr_q == SLOT_W'(SLOTS - 1)) ? '0 : nx_raddr_q + SLOT_W'(1));

  assign bdec     = $signed({rd_budget[15], rd_budget}) - 17'sd1;
  assign done_run = bdec[16] || (bdec == 17'sd0);
  assign last_k   = ((k_q + CNT_W'(1)) == ready_size_q);

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d      = state_q;
    ready_head_d = ready_head_q;
    ready_tail_d = ready_tail_q;
    ready_size_d = ready_size_q;
    free_head_d  = free_head_q;
    free_size_d  = free_size_q;
    next_id_d    = next_id_q;
    op_d         = op_q;
    name_d       = name_q;
    budget_d     = budget_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    k_d          = k_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_slot_d   = res_slot_q;

    nx_we    = 1'b0;
    nx_waddr = cur_q;
    nx_wdata = '0;
    nx_raddr = cur_q;
    dt_we    = 1'b0;
    dt_waddr = cur_q;
    dt_wdata = {name_q, budget_q, next_id_q};
    dt_raddr = cur_q;

    unique case (state_q)
      S_IDLE: begin
        nx_raddr = (opcode_i == OP_CREATE) ? free_head_q : ready_head_q;
        dt_raddr = ready_head_q;
        if (accept) begin
          op_d         = opcode_i;
          name_d       = name_tag_i[NAME_BITS-1:0];
          budget_d     = slice_budget_i;
          cur_d        = ready_head_q;
          k_d          = '0;
          res_id_d     = '0;
          res_slot_d   = '0;
          res_status_d = ST_IDLE;
          state_d      = S_DONE;
          if (opcode_i == OP_CREATE) begin
            if (free_size_q == '0) begin
              res_status_d = ST_FULL;
            end else begin
              state_d = S_CRT;
            end
          end else if (opcode_i == OP_TICK) begin
            if (ready_size_q != '0) begin
              state_d = S_TICK;
            end
          end else if (opcode_i == OP_REMOVE) begin
            if (ready_size_q == '0) begin
              res_status_d = ST_NOTFOUND;
            end else begin
              state_d = S_SRCH;
            end
          end
        end
      end
      S_CRT: begin
        // link read of the free head has landed
        dt_we       = 1'b1;
        dt_waddr    = free_head_q;
        dt_wdata    = {name_q, budget_q, next_id_q};
        nx_we       = 1'b1;
        nx_waddr    = free_head_q;
        nx_wdata    = '0;
        free_head_d = rd_next;
        free_size_d = free_size_q - CNT_W'(1);
        cur_d       = free_head_q;
        res_id_d    = next_id_q;
        res_slot_d  = free_head_q;
        next_id_d   = next_id_q + 16'd1;
        state_d     = S_APP;
      end
      S_TICK: begin
        ready_head_d = rd_next;
        ready_size_d = ready_size_q - CNT_W'(1);
        res_id_d     = rd_id;
        res_slot_d   = cur_q;
        nx_we        = 1'b1;
        nx_waddr     = cur_q;
        if (done_run) begin
          nx_wdata     = free_head_q;
          free_head_d  = cur_q;
          free_size_d  = free_size_q + CNT_W'(1);
          res_status_d = ST_FINISHED;
          state_d      = S_DONE;
        end else begin
          nx_wdata = '0;
          dt_we    = 1'b1;
          dt_waddr = cur_q;
          dt_wdata = {rd_name, bdec[15:0], rd_id};
          state_d  = S_APP;
        end
      end
      S_APP: begin
        if (ready_size_q == '0) begin
          ready_head_d = cur_q;
        end else begin
          nx_we    = 1'b1;
          nx_waddr = ready_tail_q;
          nx_wdata = cur_q;
        end
        ready_tail_d = cur_q;
        ready_size_d = ready_size_q + CNT_W'(1);
        res_status_d = (op_q == OP_CREATE) ? ST_CREATED : ST_REQUEUED;
        state_d      = S_DONE;
      end
      S_SRCH: begin
        if (rd_name == name_q) begin
          if (k_q == '0) begin
            ready_head_d = rd_next;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = prev_q;
            nx_wdata = rd_next;
            if (last_k) begin
              ready_tail_d = prev_q;
            end
          end
          ready_size_d = ready_size_q - CNT_W'(1);
          res_status_d = ST_REMOVED;
          res_id_d     = rd_id;
          res_slot_d   = cur_q;
          state_d      = S_FREE;
        end else if (last_k) begin
          res_status_d = ST_NOTFOUND;
          state_d      = S_DONE;
        end else begin
          // follow the link: next entry read issues this cycle
          prev_d   = cur_q;
          cur_d    = rd_next;
          nx_raddr = rd_next;
          dt_raddr = rd_next;
          k_d      = k_q + CNT_W'(1);
        end
      end
      S_FREE: begin
        nx_we       = 1'b1;
        nx_waddr    = cur_q;
        nx_wdata    = free_head_q;
        free_head_d = cur_q;
        free_size_d = free_size_q + CNT_W'(1);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ready_head_q <= '0;
      ready_tail_q <= '0;
      ready_size_q <= '0;
      free_head_q  <= '0;
      free_size_q  <= CNT_W'(SLOTS);
      next_id_q    <= '0;
      out_valid_q  <= 1'b0;
      nx_vld_q     <= '0;
    end else begin
      state_q      <= state_d;
      ready_head_q <= ready_head_d;
      ready_tail_q <= ready_tail_d;
      ready_size_q <= ready_size_d;
      free_head_q  <= free_head_d;
      free_size_q  <= free_size_d;
      next_id_q    <= next_id_d;
      out_valid_q  <= out_valid_d;
      if (nx_we) begin
        nx_vld_q[nx_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    name_q       <= name_d;
    budget_q     <= budget_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    k_q          <= k_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_slot_q   <= res_slot_d;
    nx_raddr_q   <= nx_raddr;
    nx_rvld_q    <= nx_vld_q[nx_raddr];
    if (out_load) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_slot_q   <= 8'(res_slot_q);
      out_ready_q  <= 9'(ready_size_q);
      out_free_q   <= 9'(free_size_q);
    end
  end

  rrs_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nx_we),
    .waddr_i (nx_waddr),
    .wdata_i (nx_wdata),
    .raddr_i (nx_raddr),
    .rdata_o (nx_rdata)
  );

  rrs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (dt_we),
    .waddr_i (dt_waddr),
    .wdata_i (dt_wdata),
    .raddr_i (dt_raddr),
    .rdata_o (dt_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign task_id_o     = out_id_q;
  assign slot_index_o  = out_slot_q;
  assign ready_count_o = out_ready_q;
  assign free_count_o  = out_free_q;

endmodule

// File: sv/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module rrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/rrs_checker.sv
// Port-level checks for the round-robin slot scheduler, bound to the top level.
// Depends on rrs_pkg for pool size and status codes.
module rrs_checker
  import rrs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [15:0] task_id_o,
  input logic [7:0]  slot_index_o,
  input logic [8:0]  ready_count_o,
  input logic [8:0]  free_count_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(task_id_o))
    else $error("stalled result beat changed");

  // one command at a time: an accepted beat closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after accept");

  // slots are either queued or free, never more than the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, ready_count_o} + {1'b0, free_count_o}) <= 10'(SLOTS)))
    else $error("slot counts exceed pool");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (free_count_o == 9'd0))
    else $error("pool full reported with free slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_FULL) || (status_o == ST_IDLE) ||
                    (status_o == ST_NOTFOUND))
    |-> (task_id_o == 16'd0) && (slot_index_o == 8'd0))
    else $error("no-op result carries task fields");

endmodule

bind round_robin_slot_scheduler rrs_checker u_rrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .task_id_o     (task_id_o),
  .slot_index_o  (slot_index_o),
  .ready_count_o (ready_count_o),
  .free_count_o  (free_count_o)
);

// File: sim/rrs_schedule_checker.sv
// Scoreboard for the round-robin slot scheduler: watches both channels, predicts each result.
// Depends on rrs_pkg for pool sizing, opcode and status codes.
module rrs_schedule_checker
  import rrs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] name_tag_i,
  input  logic [15:0] slice_budget_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] task_id_i,
  input  logic [7:0]  slot_index_i,
  input  logic [8:0]  ready_count_i,
  input  logic [8:0]  free_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] task_id;
    logic [7:0]  slot;
    logic [8:0]  ready;
    logic [8:0]  free;
  } sched_result_t;

  // shadow copy of the slot pool and both lists
  logic [7:0]           link_q [SLOTS];
  logic [NAME_BITS-1:0] tag_q  [SLOTS];
  logic [15:0]          left_q [SLOTS];
  logic [15:0]          tid_q  [SLOTS];
  logic [7:0]           ready_first, ready_last, free_first;
  int unsigned          ready_len, free_len;
  logic [15:0]          id_next;

  sched_result_t awaited_results [$];

  function automatic int unsigned slot_sel(int unsigned x);
    return (x < SLOTS) ? x : 0;
  endfunction

  function automatic void free_slot(int unsigned s);
    s = slot_sel(s);
    link_q[s]  = free_first;
    free_first = s[7:0];
    free_len++;
  endfunction

  function automatic void enqueue_ready(int unsigned s);
    s = slot_sel(s);
    link_q[s] = '0;
    if (ready_len == 0) ready_first = s[7:0];
    else link_q[slot_sel(ready_last)] = s[7:0];
    ready_last = s[7:0];
    ready_len++;
  endfunction

  function automatic sched_result_t make_result(logic [2:0] st, logic [15:0] id,
                                                int unsigned s);
    sched_result_t r;
    r.status  = st;
    r.task_id = id;
    r.slot    = s[7:0];
    r.ready   = ready_len[8:0];
    r.free    = free_len[8:0];
    return r;
  endfunction

  function automatic sched_result_t predict_step(logic [1:0] op, logic [63:0] name_full,
                                                 logic [15:0] budget);
    logic [NAME_BITS-1:0] name;
    int unsigned          s, cur, prev;
    int                   left;
    name = name_full[NAME_BITS-1:0];
    case (op)
      OP_CREATE: begin
        if (free_len == 0) return make_result(ST_FULL, '0, 0);
        s          = slot_sel(free_first);
        free_first = link_q[s];
        free_len--;
        tag_q[s]   = name;
        left_q[s]  = budget;
        tid_q[s]   = id_next;
        id_next++;
        enqueue_ready(s);
        return make_result(ST_CREATED, tid_q[s], s);
      end
      OP_TICK: begin
        if (ready_len == 0) return make_result(ST_IDLE, '0, 0);
        s           = slot_sel(ready_first);
        ready_first = link_q[s];
        ready_len--;
        // widened so the most negative budget cannot wrap
        left = int'($signed(left_q[s])) - 1;
        if (left <= 0) begin
          free_slot(s);
          return make_result(ST_FINISHED, tid_q[s], s);
        end
        left_q[s] = left[15:0];
        enqueue_ready(s);
        return make_result(ST_REQUEUED, tid_q[s], s);
      end
      OP_REMOVE: begin
        cur  = slot_sel(ready_first);
        prev = 0;
        for (int unsigned k = 0; k < ready_len; k++) begin
          if (tag_q[cur] == name) begin
            if (k == 0) begin
              ready_first = link_q[cur];
            end else begin
              link_q[prev] = link_q[cur];
              if (k + 1 == ready_len) ready_last = prev[7:0];
            end
            ready_len--;
            free_slot(cur);
            return make_result(ST_REMOVED, tid_q[cur], cur);
          end
          prev = cur;
          cur  = slot_sel(link_q[cur]);
        end
        return make_result(ST_NOTFOUND, '0, 0);
      end
      default: return make_result(ST_IDLE, '0, 0);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sched_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) link_q[i] = 8'(i + 1);
      ready_first = '0;
      ready_last  = '0;
      ready_len   = 0;
      free_first  = '0;
      free_len    = SLOTS;
      id_next     = '0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result first: a beat accepted at this edge cannot have its result yet
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing pending: status %0d", status_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (status_i !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status_i);
            fail_count_o++;
          end
          if (task_id_i !== want.task_id) begin
            $error("task_id expected %0d actual %0d", want.task_id, task_id_i);
            fail_count_o++;
          end
          if (slot_index_i !== want.slot) begin
            $error("slot_index expected %0d actual %0d", want.slot, slot_index_i);
            fail_count_o++;
          end
          if (ready_count_i !== want.ready) begin
            $error("ready_count expected %0d actual %0d", want.ready, ready_count_i);
            fail_count_o++;
          end
          if (free_count_i !== want.free) begin
            $error("free_count expected %0d actual %0d", want.free, free_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_results.push_back(predict_step(opcode_i, name_tag_i, slice_budget_i));
      pending_o = awaited_results.size();
    end
  end

endmodule

// File: sim/tb_round_robin_slot_scheduler.sv
// Testbench top for the round-robin slot scheduler: clock, reset, command stimulus, verdict.
// Depends on rrs_pkg, round_robin_slot_scheduler and rrs_schedule_checker.
module tb_round_robin_slot_scheduler
  import rrs_pkg::*;
;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_TAIL   = 50;
  // opcode with no command behind it
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode       = '0;
  logic [63:0] name_tag     = '0;
  logic [15:0] slice_budget = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [2:0]  status;
  logic [15:0] task_id;
  logic [7:0]  slot_index;
  logic [8:0]  ready_count;
  logic [8:0]  free_count;

  int          fail_count;
  int          pending;
  int unsigned cycles     = 0;
  int unsigned beats_sent = 0;
  bit          idle_off   = 1'b0;
  logic [63:0] name_pool [6];

  always #6 clk = ~clk;

  round_robin_slot_scheduler i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .name_tag_i    (name_tag),
    .slice_budget_i(slice_budget),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .task_id_o     (task_id),
    .slot_index_o  (slot_index),
    .ready_count_o (ready_count),
    .free_count_o  (free_count)
  );

  rrs_schedule_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .opcode_i      (opcode),
    .name_tag_i    (name_tag),
    .slice_budget_i(slice_budget),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .status_i      (status),
    .task_id_i     (task_id),
    .slot_index_i  (slot_index),
    .ready_count_i (ready_count),
    .free_count_i  (free_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stall bursts, none once idling is switched off
  initial begin
    forever begin
      if (!idle_off && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // drive one command beat and hold it until accepted
  task automatic issue_command(logic [1:0] op, logic [63:0] name, logic [15:0] budget);
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    name_tag     <= name;
    slice_budget <= budget;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [15:0] pick_budget();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return 16'd0 - 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(1, 5));
    endcase
  endfunction

  // mostly names already in use, so removes hit and duplicates occur
  function automatic logic [63:0] pick_name();
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    return name_pool[$urandom_range(0, 5)];
  endfunction

  initial begin : stimulus
    int unsigned base;
    int          len;
    for (int i = 0; i < 6; i++) name_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty ready queue corner cases and the unused opcode
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_REMOVE, '0, '0);
    issue_command(OP_SPARE, '0, '0);
    // field extremes; name zero twice to check first-match remove
    issue_command(OP_CREATE, 64'h0, 16'd1);
    issue_command(OP_CREATE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    issue_command(OP_CREATE, 64'h0123_4567_89AB_CDEF, 16'h8000);
    issue_command(OP_CREATE, 64'h8000_0000_0000_0001, 16'h7FFF);
    issue_command(OP_CREATE, 64'h0, 16'd2);
    issue_command(OP_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    // remove at head, middle, tail, then a miss on a non-empty queue
    issue_command(OP_REMOVE, 64'h0, '0);
    issue_command(OP_REMOVE, 64'h8000_0000_0000_0001, '0);
    issue_command(OP_REMOVE, 64'h0, '0);
    issue_command(OP_REMOVE, 64'hDEAD_BEEF_DEAD_BEEF, '0);
    // zero and most negative budgets finish at the first tick
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_CREATE, 64'h5555_5555_5555_5555, 16'd3);
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_CREATE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h7FFF);
    issue_command(OP_TICK, '0, '0);
    issue_command(OP_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA, '0);

    base = beats_sent;
    while (beats_sent - base < RANDOM_ITEMS) begin
      if (beats_sent - base >= RANDOM_ITEMS - QUIET_TAIL) idle_off = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // long bursts run the pool dry
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
          repeat (len) issue_command(OP_CREATE, pick_name(), pick_budget());
        end
        4, 5, 6: begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
          repeat (len) issue_command(OP_TICK, {$urandom, $urandom}, 16'($urandom));
        end
        7, 8: begin
          len = $urandom_range(1, 4);
          repeat (len) issue_command(OP_REMOVE, pick_name(), 16'($urandom));
        end
        default: begin
          name_pool[$urandom_range(0, 5)] = {$urandom, $urandom};
          issue_command(2'($urandom_range(0, 3)), {$urandom, $urandom}, pick_budget());
        end
      endcase
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
